/* hw/rtl/btb_pkg.sv */
// Shared types, constants and register codes of the branch target buffer predictor.
`timescale 1ns / 1ps

package btb_pkg;

   // Default sizing of the buffer and of the history.
   localparam int MAX_ENTRIES_DEF = 32;
   localparam int MAX_HISTORY_DEF = 8;

   // Fixed field widths.
   localparam int PC_W       = 32;
   localparam int TAG_W      = 30;
   localparam int TAG_MAX    = 30;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Address arithmetic: instruction step, index base bit and xor sources.
   localparam int PC_STEP  = 4;
   localparam int IDX_LSB  = 2;
   localparam int XOR_LOW  = 2;
   localparam int XOR_HIGH = 16;

   // Two-bit counter limits.
   localparam logic [1:0] CTR_MIN = 2'd0;
   localparam logic [1:0] CTR_MAX = 2'd3;

   // Register reset values.
   localparam logic [2:0] RST_ENTRIES_LOG2   = 3'd5;
   localparam logic [3:0] RST_HISTORY_LENGTH = 4'd8;
   localparam logic [4:0] RST_TAG_BITS       = 5'd30;
   localparam logic [1:0] RST_COUNTER_RESET  = 2'd1;

   // Register indexes, at byte address four times the index.
   typedef enum logic [2:0] {
      REG_ENTRIES_LOG2,
      REG_HISTORY_LENGTH,
      REG_TAG_BITS,
      REG_COUNTER_RESET,
      REG_HISTORY_IS_GLOBAL,
      REG_TABLE_IS_GLOBAL,
      REG_SHARE_MODE
   } reg_index_type;

   // Index xor source.
   typedef enum logic [1:0] {
      SHARE_NONE,
      SHARE_LOW,
      SHARE_HIGH
   } share_type;

   // Request kind.
   typedef enum logic {
      ACT_PREDICT,
      ACT_UPDATE
   } action_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EXEC
   } state_type;

   // Effective configuration, already clamped to legal values.
   typedef struct packed {
      logic [2:0] entries_log2;
      logic [3:0] history_length;
      logic [4:0] tag_bits;
      logic [1:0] counter_reset;
      logic       history_is_global;
      logic       table_is_global;
      share_type  share_mode;
   } cfg_type;

endpackage

/* hw/rtl/btb_csr.sv */
// Configuration registers with their bus port and the clamped view used by the datapath.
`timescale 1ns / 1ps

module btb_csr #(
   parameter int MAX_ENTRIES = btb_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_HISTORY = btb_pkg::MAX_HISTORY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [btb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [btb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [btb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output btb_pkg::cfg_type                  cfg,
   output logic                              clear_shared
);

   // Largest entry count exponent that fits the buffer.
   localparam int LOG2_MAX = $clog2(MAX_ENTRIES + 1) - 1;

   logic [2:0] entries_log2_ff,   entries_log2_in;
   logic [3:0] history_length_ff, history_length_in;
   logic [4:0] tag_bits_ff,       tag_bits_in;
   logic [1:0] counter_reset_ff,  counter_reset_in;
   logic       history_global_ff, history_global_in;
   logic       table_global_ff,   table_global_in;
   logic [1:0] share_mode_ff,     share_mode_in;

   logic                   wr_fire;
   btb_pkg::reg_index_type reg_sel;

   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = btb_pkg::reg_index_type'(csr_paddr[btb_pkg::CSR_ADDR_W-1:2]);

   // A transfer that writes the counter start value also reloads the shared table.
   assign clear_shared = wr_fire && (reg_sel == btb_pkg::REG_COUNTER_RESET);

   // Next register values on a write transfer.
   always_comb begin
      entries_log2_in   = entries_log2_ff;
      history_length_in = history_length_ff;
      tag_bits_in       = tag_bits_ff;
      counter_reset_in  = counter_reset_ff;
      history_global_in = history_global_ff;
      table_global_in   = table_global_ff;
      share_mode_in     = share_mode_ff;
      if (wr_fire) begin
         case (reg_sel)
            btb_pkg::REG_ENTRIES_LOG2:      entries_log2_in   = csr_pwdata[2:0];
            btb_pkg::REG_HISTORY_LENGTH:    history_length_in = csr_pwdata[3:0];
            btb_pkg::REG_TAG_BITS:          tag_bits_in       = csr_pwdata[4:0];
            btb_pkg::REG_COUNTER_RESET:     counter_reset_in  = csr_pwdata[1:0];
            btb_pkg::REG_HISTORY_IS_GLOBAL: history_global_in = csr_pwdata[0];
            btb_pkg::REG_TABLE_IS_GLOBAL:   table_global_in   = csr_pwdata[0];
            btb_pkg::REG_SHARE_MODE:        share_mode_in     = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_log2_ff   <= btb_pkg::RST_ENTRIES_LOG2;
         history_length_ff <= btb_pkg::RST_HISTORY_LENGTH;
         tag_bits_ff       <= btb_pkg::RST_TAG_BITS;
         counter_reset_ff  <= btb_pkg::RST_COUNTER_RESET;
         history_global_ff <= 1'b0;
         table_global_ff   <= 1'b0;
         share_mode_ff     <= 2'd0;
      end else begin
         entries_log2_ff   <= entries_log2_in;
         history_length_ff <= history_length_in;
         tag_bits_ff       <= tag_bits_in;
         counter_reset_ff  <= counter_reset_in;
         history_global_ff <= history_global_in;
         table_global_ff   <= table_global_in;
         share_mode_ff     <= share_mode_in;
      end
   end

   // Read data returns the stored register value.
   always_comb begin
      csr_prdata = '0;
      case (reg_sel)
         btb_pkg::REG_ENTRIES_LOG2:      csr_prdata[2:0] = entries_log2_ff;
         btb_pkg::REG_HISTORY_LENGTH:    csr_prdata[3:0] = history_length_ff;
         btb_pkg::REG_TAG_BITS:          csr_prdata[4:0] = tag_bits_ff;
         btb_pkg::REG_COUNTER_RESET:     csr_prdata[1:0] = counter_reset_ff;
         btb_pkg::REG_HISTORY_IS_GLOBAL: csr_prdata[0]   = history_global_ff;
         btb_pkg::REG_TABLE_IS_GLOBAL:   csr_prdata[0]   = table_global_ff;
         btb_pkg::REG_SHARE_MODE:        csr_prdata[1:0] = share_mode_ff;
         default:                        csr_prdata      = '0;
      endcase
   end

   // Clamp the raw values into the ranges the datapath handles.
   always_comb begin
      cfg = '0;
      if (int'(entries_log2_ff) > LOG2_MAX) begin
         cfg.entries_log2 = 3'(LOG2_MAX);
      end else begin
         cfg.entries_log2 = entries_log2_ff;
      end
      if (history_length_ff == 4'd0) begin
         cfg.history_length = 4'd1;
      end else if (int'(history_length_ff) > MAX_HISTORY) begin
         cfg.history_length = 4'(MAX_HISTORY);
      end else begin
         cfg.history_length = history_length_ff;
      end
      if (int'(tag_bits_ff) > btb_pkg::TAG_MAX) begin
         cfg.tag_bits = 5'(btb_pkg::TAG_MAX);
      end else begin
         cfg.tag_bits = tag_bits_ff;
      end
      cfg.counter_reset     = counter_reset_ff;
      cfg.history_is_global = history_global_ff;
      cfg.table_is_global   = table_global_ff;
      case (share_mode_ff)
         2'd1:    cfg.share_mode = btb_pkg::SHARE_LOW;
         2'd2:    cfg.share_mode = btb_pkg::SHARE_HIGH;
         default: cfg.share_mode = btb_pkg::SHARE_NONE;
      endcase
   end

endmodule

/* hw/rtl/btb_entry_store.sv */
// Per-entry storage: valid flags plus one memory holding tag, target, history and counter row.
`timescale 1ns / 1ps

module btb_entry_store #(
   parameter int MAX_ENTRIES = btb_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_HISTORY = btb_pkg::MAX_HISTORY_DEF,
   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int ROW_W  = 2 * (2 ** MAX_HISTORY)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic                          rd_valid,
   output logic [btb_pkg::TAG_W-1:0]     rd_tag,
   output logic [btb_pkg::PC_W-1:0]      rd_target,
   output logic [MAX_HISTORY-1:0]        rd_hist,
   output logic [ROW_W-1:0]              rd_row,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [btb_pkg::TAG_W-1:0]     wr_tag,
   input  logic [btb_pkg::PC_W-1:0]      wr_target,
   input  logic [MAX_HISTORY-1:0]        wr_hist,
   input  logic [ROW_W-1:0]              wr_row
);

   localparam int WORD_W = btb_pkg::TAG_W + btb_pkg::PC_W + MAX_HISTORY + ROW_W;

   logic [WORD_W-1:0]      entry_mem [MAX_ENTRIES];
   logic [WORD_W-1:0]      rd_word_ff;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic                   rd_valid_ff;

   // Valid flags live in flip-flops so reset empties the buffer at once.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Synchronous memory, registered read of the whole entry word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= {wr_tag, wr_target, wr_hist, wr_row};
      end
      if (rd_en) begin
         rd_word_ff  <= entry_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign {rd_tag, rd_target, rd_hist, rd_row} = rd_word_ff;

endmodule

/* hw/rtl/btb_shared_table.sv */
// Shared pattern counter table with per-counter valid flags for fast reload.
`timescale 1ns / 1ps

module btb_shared_table #(
   parameter int MAX_HISTORY = btb_pkg::MAX_HISTORY_DEF,
   localparam int DEPTH = 2 ** MAX_HISTORY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic [1:0]             counter_reset,
   input  logic                   rd_en,
   input  logic [MAX_HISTORY-1:0] rd_addr,
   output logic [1:0]             rd_value,
   input  logic                   wr_en,
   input  logic [MAX_HISTORY-1:0] wr_addr,
   input  logic [1:0]             wr_value
);

   logic [1:0]       ctr_mem [DEPTH];
   logic [1:0]       rd_data_ff;
   logic             rd_hit_ff;
   logic [DEPTH-1:0] valid_ff, valid_in;

   // A counter without its valid flag reads as the current start value.
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ctr_mem[wr_addr] <= wr_value;
      end
      if (rd_en) begin
         rd_data_ff <= ctr_mem[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_value = rd_hit_ff ? rd_data_ff : counter_reset;

endmodule

/* hw/rtl/btb_two_level_branch_predictor_core.sv */
// Top level of the two-level branch predictor with branch target buffer.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  action, branch_pc, resolved_target, was_taken
//   rsp      out        rsp_valid/rsp_stall  predict_taken, predicted_target
//   csr      in/out     psel/penable/pready  register write and read, 32-bit data
//
// Each request passes three steps: the transfer cycle issues the entry memory read,
// the lookup cycle checks the tag and reads the shared counter table, and the execute
// cycle selects the counter, writes back and loads the result register.
// Only predicts return a result; updates return none.
// A prediction holds in execute while an earlier prediction still waits in the result register.
// Reset is synchronous; valid flags are flip-flops cleared at once, with no clearing pass.
`timescale 1ns / 1ps

module btb_two_level_branch_predictor_core #(
   parameter int MAX_ENTRIES = btb_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_HISTORY = btb_pkg::MAX_HISTORY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [btb_pkg::PC_W-1:0]        req_branch_pc,
   input  logic [btb_pkg::PC_W-1:0]        req_resolved_target,
   input  logic                            req_was_taken,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_predict_taken,
   output logic [btb_pkg::PC_W-1:0]        rsp_predicted_target,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [btb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [btb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [btb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int HIST_W = MAX_HISTORY;
   localparam int ROWS   = 2 ** MAX_HISTORY;
   localparam int ROW_W  = 2 * ROWS;

   btb_pkg::cfg_type cfg;
   logic             clear_shared;

   btb_pkg::state_type state_ff, state_in;

   // Request registers.
   btb_pkg::action_type     req_action_ff;
   logic [btb_pkg::PC_W-1:0] pc_ff, target_ff;
   logic                     taken_ff;
   logic [IDX_W-1:0]         slot_ff;

   // Lookup results carried into execute.
   logic                       hit_ff;
   logic [HIST_W-1:0]          idx_ff, hist_ff;
   logic [btb_pkg::TAG_W-1:0]  tag_ff;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_taken_ff;
   logic [btb_pkg::PC_W-1:0]   rsp_target_ff;

   logic [HIST_W-1:0]          shared_hist_ff, shared_hist_in;

   // Sequencer strobes.
   logic accept, in_lookup, exec_go;

   // Entry store read data.
   logic                       ent_valid;
   logic [btb_pkg::TAG_W-1:0]  ent_tag;
   logic [btb_pkg::PC_W-1:0]   ent_target;
   logic [HIST_W-1:0]          ent_hist;
   logic [ROW_W-1:0]           ent_row;

   // Datapath nets.
   logic [IDX_W-1:0]           emask, rd_slot;
   logic [btb_pkg::PC_W-1:0]   tag_shift;
   logic [btb_pkg::TAG_W-1:0]  tag_cur, tmask;
   logic                       hit_cur;
   logic [HIST_W-1:0]          hmask, hist_sel, xor_bits, idx_cur;
   logic [1:0]                 shared_val, row_val, ctr_old, ctr_new;
   logic                       pred_taken;
   logic [btb_pkg::PC_W-1:0]   pred_target;
   logic [HIST_W-1:0]          hist_new, hist_wr;
   logic [ROW_W-1:0]           row_wr;
   logic                       do_update;

   btb_csr #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .MAX_HISTORY(MAX_HISTORY)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .cfg          (cfg),
      .clear_shared (clear_shared)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         btb_pkg::ST_IDLE:   if (req_valid) state_in = btb_pkg::ST_LOOKUP;
         btb_pkg::ST_LOOKUP: state_in = btb_pkg::ST_EXEC;
         btb_pkg::ST_EXEC:   if (exec_go) state_in = btb_pkg::ST_IDLE;
         default:            state_in = btb_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs; execute waits only when a prediction would overwrite a held result.
   always_comb begin
      req_stall = 1'b1;
      in_lookup = 1'b0;
      exec_go   = 1'b0;
      case (state_ff)
         btb_pkg::ST_IDLE:   req_stall = 1'b0;
         btb_pkg::ST_LOOKUP: in_lookup = 1'b1;
         btb_pkg::ST_EXEC:   exec_go = (req_action_ff == btb_pkg::ACT_UPDATE)
                                       || !rsp_valid_ff || !rsp_stall;
         default:            req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Slot of the incoming pc addresses the entry memory in the transfer cycle.
   assign emask   = ~({IDX_W{1'b1}} << cfg.entries_log2);
   assign rd_slot = req_branch_pc[btb_pkg::IDX_LSB +: IDX_W] & emask;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_action_ff <= btb_pkg::action_type'(req_action);
         pc_ff         <= req_branch_pc;
         target_ff     <= req_resolved_target;
         taken_ff      <= req_was_taken;
         slot_ff       <= rd_slot;
      end
   end

   btb_entry_store #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .MAX_HISTORY(MAX_HISTORY)
   ) u_entry_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (rd_slot),
      .rd_valid  (ent_valid),
      .rd_tag    (ent_tag),
      .rd_target (ent_target),
      .rd_hist   (ent_hist),
      .rd_row    (ent_row),
      .wr_en     (do_update),
      .wr_addr   (slot_ff),
      .wr_tag    (tag_ff),
      .wr_target (target_ff),
      .wr_hist   (hist_wr),
      .wr_row    (row_wr)
   );

   // Tag is the pc above the index bits, cut to the configured width.
   assign tag_shift = pc_ff >> (6'(btb_pkg::IDX_LSB) + 6'(cfg.entries_log2));
   assign tmask     = ~({btb_pkg::TAG_W{1'b1}} << cfg.tag_bits);
   assign tag_cur   = tag_shift[btb_pkg::TAG_W-1:0] & tmask;
   assign hit_cur   = ent_valid && (ent_tag == tag_cur);

   // History feeding the counter index; a freshly allocated entry starts with none.
   always_comb begin
      if (cfg.history_is_global) begin
         hist_sel = shared_hist_ff;
      end else if (hit_cur) begin
         hist_sel = ent_hist;
      end else begin
         hist_sel = '0;
      end
   end

   // Counter index: history xor the selected pc bits, masked to the history length.
   always_comb begin
      case (cfg.share_mode)
         btb_pkg::SHARE_LOW:  xor_bits = pc_ff[btb_pkg::XOR_LOW +: HIST_W];
         btb_pkg::SHARE_HIGH: xor_bits = pc_ff[btb_pkg::XOR_HIGH +: HIST_W];
         default:             xor_bits = '0;
      endcase
   end

   assign hmask   = ~({HIST_W{1'b1}} << cfg.history_length);
   assign idx_cur = (hist_sel ^ xor_bits) & hmask;

   always_ff @(posedge clock) begin
      if (in_lookup) begin
         hit_ff  <= hit_cur;
         idx_ff  <= idx_cur;
         hist_ff <= hist_sel;
         tag_ff  <= tag_cur;
      end
   end

   btb_shared_table #(
      .MAX_HISTORY(MAX_HISTORY)
   ) u_shared_table (
      .clock         (clock),
      .reset         (reset),
      .clear         (clear_shared),
      .counter_reset (cfg.counter_reset),
      .rd_en         (in_lookup),
      .rd_addr       (idx_cur),
      .rd_value      (shared_val),
      .wr_en         (do_update && cfg.table_is_global),
      .wr_addr       (idx_ff),
      .wr_value      (ctr_new)
   );

   // Counter selection and training in the execute cycle.
   assign row_val = ent_row[{idx_ff, 1'b0} +: 2];

   always_comb begin
      if (cfg.table_is_global) begin
         ctr_old = shared_val;
      end else if (hit_ff) begin
         ctr_old = row_val;
      end else begin
         ctr_old = cfg.counter_reset;
      end
      if (taken_ff) begin
         ctr_new = (ctr_old == btb_pkg::CTR_MAX) ? ctr_old : ctr_old + 2'd1;
      end else begin
         ctr_new = (ctr_old == btb_pkg::CTR_MIN) ? ctr_old : ctr_old - 2'd1;
      end
   end

   // Prediction: weakly taken or above on a hit gives the stored target.
   assign pred_taken  = hit_ff && ctr_old[1];
   assign pred_target = pred_taken ? ent_target : pc_ff + btb_pkg::PC_W'(btb_pkg::PC_STEP);

   // Outcome enters at the top of the used history, older bits move down.
   assign hist_new = ((hist_ff & hmask) >> 1)
                     | (HIST_W'(taken_ff) << (cfg.history_length - 4'd1));

   assign do_update = exec_go && (req_action_ff == btb_pkg::ACT_UPDATE);

   // Write-back data for the entry word.
   always_comb begin
      if (!cfg.history_is_global) begin
         hist_wr = hist_new;
      end else if (hit_ff) begin
         hist_wr = ent_hist;
      end else begin
         hist_wr = '0;
      end
      if (hit_ff) begin
         row_wr = ent_row;
      end else begin
         row_wr = {ROWS{cfg.counter_reset}};
      end
      if (!cfg.table_is_global) begin
         row_wr[{idx_ff, 1'b0} +: 2] = ctr_new;
      end
   end

   // Shared history register.
   always_comb begin
      shared_hist_in = shared_hist_ff;
      if (do_update && cfg.history_is_global) begin
         shared_hist_in = hist_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_hist_ff <= '0;
      end else begin
         shared_hist_ff <= shared_hist_in;
      end
   end

   // Result register: loads on a finished prediction, empties on a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (exec_go && (req_action_ff == btb_pkg::ACT_PREDICT)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && (req_action_ff == btb_pkg::ACT_PREDICT)) begin
         rsp_taken_ff  <= pred_taken;
         rsp_target_ff <= pred_target;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predict_taken    = rsp_taken_ff;
   assign rsp_predicted_target = rsp_target_ff;

   // The input side is closed whenever a request is in flight.
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != btb_pkg::ST_IDLE) |-> req_stall)
      else $error("request side open while a request is in flight");

   // An accepted request moves straight into lookup.
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == btb_pkg::ST_LOOKUP))
      else $error("accepted request did not enter lookup");

   // Lookup always moves on to execute in the next cycle.
   a_lookup_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == btb_pkg::ST_LOOKUP) |=> (state_ff == btb_pkg::ST_EXEC))
      else $error("lookup did not advance to execute");

   // A new result only comes from executing a prediction.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(state_ff == btb_pkg::ST_EXEC && req_action_ff == btb_pkg::ACT_PREDICT))
      else $error("result appeared without a prediction");

endmodule

/* verif/tb_btb_two_level_branch_predictor_core.sv */
// Self-checking testbench for the two-level branch predictor with branch target buffer.
`timescale 1ns / 1ps

module tb_btb_two_level_branch_predictor_core;

   localparam int CLK_PERIOD    = 4;
   localparam int CTR_SLOTS     = 1 << btb_pkg::MAX_HISTORY_DEF;
   localparam int POOL_SIZE     = 12;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 500000;

   // One branch operation as it is sent to the block.
   typedef struct {
      btb_pkg::action_type act;
      logic [31:0]         pc;
      logic [31:0]         target;
      logic                taken;
      bit                  drain_first;
   } branch_op_type;

   // One prediction as the block should return it.
   typedef struct {
      logic        taken;
      logic [31:0] target;
   } prediction_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_action = 1'b0;
   logic [btb_pkg::PC_W-1:0]       req_branch_pc = '0;
   logic [btb_pkg::PC_W-1:0]       req_resolved_target = '0;
   logic                           req_was_taken = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_predict_taken;
   logic [btb_pkg::PC_W-1:0]       rsp_predicted_target;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [btb_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [btb_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [btb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   btb_two_level_branch_predictor_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_branch_pc        (req_branch_pc),
      .req_resolved_target  (req_resolved_target),
      .req_was_taken        (req_was_taken),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_predict_taken    (rsp_predict_taken),
      .rsp_predicted_target (rsp_predicted_target),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Predictor copy of the configuration registers, raw as written.
   logic [2:0] cfg_entries_log2 = btb_pkg::RST_ENTRIES_LOG2;
   logic [3:0] cfg_history_length = btb_pkg::RST_HISTORY_LENGTH;
   logic [4:0] cfg_tag_bits = btb_pkg::RST_TAG_BITS;
   logic [1:0] cfg_counter_reset = btb_pkg::RST_COUNTER_RESET;
   logic       cfg_history_is_global = 1'b0;
   logic       cfg_table_is_global = 1'b0;
   logic [1:0] cfg_share_mode = btb_pkg::SHARE_NONE;

   // Predictor copy of the buffer, histories and counter tables.
   bit          bank_valid [btb_pkg::MAX_ENTRIES_DEF];
   logic [29:0] bank_tag [btb_pkg::MAX_ENTRIES_DEF];
   logic [31:0] bank_target [btb_pkg::MAX_ENTRIES_DEF];
   logic [7:0]  bank_hist [btb_pkg::MAX_ENTRIES_DEF];
   logic [1:0]  bank_ctr [btb_pkg::MAX_ENTRIES_DEF][CTR_SLOTS];
   logic [7:0]  shared_hist = '0;
   logic [1:0]  shared_ctr [CTR_SLOTS];

   branch_op_type  pending_ops[$];
   prediction_type predictions_due[$];
   int unsigned queued_ops = 0;
   int unsigned accepted_ops = 0;
   int unsigned mismatch_count = 0;
   int unsigned req_idle_pct = 30;
   int unsigned rsp_idle_pct = 30;
   int unsigned cycle_count = 0;

   initial begin
      for (int i = 0; i < btb_pkg::MAX_ENTRIES_DEF; i++) bank_valid[i] = 1'b0;
      for (int i = 0; i < CTR_SLOTS; i++) shared_ctr[i] = btb_pkg::RST_COUNTER_RESET;
   end

   // Entries in use: oversize settings shrink until they fit the buffer.
   function automatic int unsigned used_log2();
      int unsigned e;
      e = cfg_entries_log2;
      while (e > 0 && (1 << e) > btb_pkg::MAX_ENTRIES_DEF) e--;
      return e;
   endfunction

   function automatic int unsigned used_hist_len();
      int unsigned len;
      len = cfg_history_length;
      if (len < 1) len = 1;
      if (len > btb_pkg::MAX_HISTORY_DEF) len = btb_pkg::MAX_HISTORY_DEF;
      return len;
   endfunction

   function automatic int unsigned entry_of(logic [31:0] pc);
      return (pc >> btb_pkg::IDX_LSB) & ((1 << used_log2()) - 1);
   endfunction

   function automatic int unsigned tag_of_pc(logic [31:0] pc);
      int unsigned tb;
      tb = (cfg_tag_bits > btb_pkg::TAG_MAX) ? btb_pkg::TAG_MAX : cfg_tag_bits;
      return (pc >> (btb_pkg::IDX_LSB + used_log2())) & ((32'd1 << tb) - 1);
   endfunction

   // Counter index: history xor the selected pc bits, cut to the history length.
   function automatic int unsigned counter_index(logic [31:0] pc, logic [7:0] hist);
      int unsigned mask;
      int unsigned idx;
      mask = (1 << used_hist_len()) - 1;
      idx = hist & mask;
      if (cfg_share_mode == btb_pkg::SHARE_LOW) idx = idx ^ (pc >> btb_pkg::XOR_LOW);
      else if (cfg_share_mode == btb_pkg::SHARE_HIGH) idx = idx ^ (pc >> btb_pkg::XOR_HIGH);
      return idx & mask;
   endfunction

   // Looks up or trains the predictor; returns 1 when a prediction comes out.
   function automatic bit predict_and_train(input branch_op_type op,
                                            output prediction_type res);
      int unsigned slot;
      int unsigned pos;
      int unsigned len;
      bit          hit;
      logic [7:0]  hist;
      logic [1:0]  ctr;
      slot = entry_of(op.pc);
      hit = bank_valid[slot] && (bank_tag[slot] == tag_of_pc(op.pc));
      res.taken = 1'b0;
      res.target = op.pc + btb_pkg::PC_STEP;
      if (op.act == btb_pkg::ACT_PREDICT) begin
         if (hit) begin
            hist = cfg_history_is_global ? shared_hist : bank_hist[slot];
            pos = counter_index(op.pc, hist);
            ctr = cfg_table_is_global ? shared_ctr[pos] : bank_ctr[slot][pos];
            if (ctr >= 2'd2) begin
               res.taken = 1'b1;
               res.target = bank_target[slot];
            end
         end
         return 1'b1;
      end
      // A miss claims the entry and restarts its local history and counters.
      if (!hit) begin
         bank_valid[slot] = 1'b1;
         bank_tag[slot] = 30'(tag_of_pc(op.pc));
         bank_target[slot] = op.pc + btb_pkg::PC_STEP;
         bank_hist[slot] = '0;
         for (int i = 0; i < CTR_SLOTS; i++) bank_ctr[slot][i] = cfg_counter_reset;
      end
      hist = cfg_history_is_global ? shared_hist : bank_hist[slot];
      pos = counter_index(op.pc, hist);
      ctr = cfg_table_is_global ? shared_ctr[pos] : bank_ctr[slot][pos];
      if (op.taken) begin
         if (ctr != btb_pkg::CTR_MAX) ctr = ctr + 2'd1;
      end else if (ctr != btb_pkg::CTR_MIN) begin
         ctr = ctr - 2'd1;
      end
      if (cfg_table_is_global) shared_ctr[pos] = ctr;
      else bank_ctr[slot][pos] = ctr;
      // The outcome enters at the top of the used history.
      len = used_hist_len();
      hist = 8'(((hist & 8'((1 << len) - 1)) >> 1) | (8'(op.taken) << (len - 1)));
      if (cfg_history_is_global) shared_hist = hist;
      else bank_hist[slot] = hist;
      bank_target[slot] = op.target;
      return 1'b0;
   endfunction

   // Random idle run: none unless a roll falls under pct, then mostly short, rarely long.
   function automatic int unsigned pick_gap(int unsigned pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Request driver: presents queued operations and records each transfer.
   int unsigned send_gap = 0;
   always @(posedge clock) begin
      branch_op_type  op;
      prediction_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            op.act = btb_pkg::action_type'(req_action);
            op.pc = req_branch_pc;
            op.target = req_resolved_target;
            op.taken = req_was_taken;
            op.drain_first = 1'b0;
            if (predict_and_train(op, res)) predictions_due.insert(predictions_due.size(), res);
            accepted_ops++;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].drain_first && predictions_due.size() != 0)) begin
               op = pending_ops.pop_front();
               req_action <= op.act;
               req_branch_pc <= op.pc;
               req_resolved_target <= op.target;
               req_was_taken <= op.taken;
               req_valid <= 1'b1;
               send_gap = pick_gap(req_idle_pct);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transfer against the oldest prediction due and drives random stalls.
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      prediction_type exp_res;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predictions_due.size() == 0) begin
               $display("%0t: result with no prediction due: taken %0d target %h",
                        $time, rsp_predict_taken, rsp_predicted_target);
               mismatch_count++;
            end else begin
               exp_res = predictions_due.pop_front();
               if (rsp_predict_taken !== exp_res.taken) begin
                  $display("%0t: predict_taken expected %0d, got %0d",
                           $time, exp_res.taken, rsp_predict_taken);
                  mismatch_count++;
               end
               if (rsp_predicted_target !== exp_res.target) begin
                  $display("%0t: predicted_target expected %h, got %h",
                           $time, exp_res.target, rsp_predicted_target);
                  mismatch_count++;
               end
            end
         end
         if (stall_left == 0) stall_left = pick_gap(rsp_idle_pct);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_op(btb_pkg::action_type act, logic [31:0] pc, logic [31:0] target,
                           logic taken, bit drain_first);
      branch_op_type op;
      op.act = act;
      op.pc = pc;
      op.target = target;
      op.taken = taken;
      op.drain_first = drain_first;
      pending_ops.insert(pending_ops.size(), op);
      queued_ops++;
   endtask

   // Waits until every operation is transferred and every prediction has come back.
   task automatic wait_idle();
      while (accepted_ops != queued_ops || predictions_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(btb_pkg::reg_index_type idx,
                            logic [btb_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= btb_pkg::CSR_ADDR_W'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         btb_pkg::REG_ENTRIES_LOG2:      cfg_entries_log2 = value[2:0];
         btb_pkg::REG_HISTORY_LENGTH:    cfg_history_length = value[3:0];
         btb_pkg::REG_TAG_BITS:          cfg_tag_bits = value[4:0];
         btb_pkg::REG_COUNTER_RESET: begin
            // Writing the start value also reloads the shared table.
            cfg_counter_reset = value[1:0];
            for (int i = 0; i < CTR_SLOTS; i++) shared_ctr[i] = value[1:0];
         end
         btb_pkg::REG_HISTORY_IS_GLOBAL: cfg_history_is_global = value[0];
         btb_pkg::REG_TABLE_IS_GLOBAL:   cfg_table_is_global = value[0];
         btb_pkg::REG_SHARE_MODE:        cfg_share_mode = value[1:0];
         default: ;
      endcase
   endtask

   // Mostly predict-then-update pairs over a small set of branches with
   // periodic outcomes, some sharing an entry; the rest is random noise.
   task automatic random_traffic(int unsigned n_ops);
      logic [31:0] pool_pc [POOL_SIZE];
      logic [31:0] pool_target [POOL_SIZE];
      logic [7:0]  pattern [POOL_SIZE];
      int unsigned period [POOL_SIZE];
      int unsigned visits [POOL_SIZE];
      int unsigned sent;
      int unsigned pick;
      int unsigned roll;
      logic        outcome;
      bit          hold;
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_pc[k] = $urandom;
         if (k > 0 && $urandom_range(2) == 0) begin
            pool_pc[k][6:0] = pool_pc[$urandom_range(k - 1)][6:0];
         end
         pool_target[k] = $urandom;
         pattern[k] = 8'($urandom);
         period[k] = $urandom_range(1, 6);
         visits[k] = 0;
      end
      sent = 0;
      while (sent < n_ops) begin
         hold = ($urandom_range(99) == 0);
         roll = $urandom_range(99);
         if (roll < 80) begin
            pick = $urandom_range(POOL_SIZE - 1);
            outcome = pattern[pick][visits[pick] % period[pick]];
            if ($urandom_range(9) == 0) outcome = ~outcome;
            visits[pick]++;
            if ($urandom_range(19) == 0) pool_target[pick] = $urandom;
            queue_op(btb_pkg::ACT_PREDICT, pool_pc[pick], $urandom,
                     1'($urandom_range(1)), hold);
            queue_op(btb_pkg::ACT_UPDATE, pool_pc[pick], pool_target[pick], outcome, 1'b0);
            sent += 2;
         end else if (roll < 90) begin
            queue_op(btb_pkg::ACT_PREDICT, $urandom, $urandom, 1'($urandom_range(1)), hold);
            sent++;
         end else begin
            queue_op(btb_pkg::ACT_UPDATE, $urandom, $urandom, 1'($urandom_range(1)), hold);
            sent++;
         end
      end
   endtask

   // One setting of every register, then random traffic under it.
   task automatic run_phase(logic [2:0] entries_log2, logic [3:0] history_length,
                            logic [4:0] tag_bits, logic [1:0] counter_reset,
                            logic history_global, logic table_global,
                            logic [1:0] share_mode, int unsigned idle_pct,
                            int unsigned n_ops);
      wait_idle();
      csr_write(btb_pkg::REG_ENTRIES_LOG2, 32'(entries_log2));
      csr_write(btb_pkg::REG_HISTORY_LENGTH, 32'(history_length));
      csr_write(btb_pkg::REG_TAG_BITS, 32'(tag_bits));
      csr_write(btb_pkg::REG_COUNTER_RESET, 32'(counter_reset));
      csr_write(btb_pkg::REG_HISTORY_IS_GLOBAL, 32'(history_global));
      csr_write(btb_pkg::REG_TABLE_IS_GLOBAL, 32'(table_global));
      csr_write(btb_pkg::REG_SHARE_MODE, 32'(share_mode));
      req_idle_pct = idle_pct;
      rsp_idle_pct = idle_pct;
      random_traffic(n_ops);
   endtask

   // Main sequence. Shared history and table are only ever switched on, never
   // off, so no entry reads local state that was never written.
   initial begin
      logic hist_first;
      hist_first = 1'($urandom_range(1));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings: empty buffer, pc wrap, allocation,
      // saturation both ways, and an alias that evicts the entry.
      queue_op(btb_pkg::ACT_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      queue_op(btb_pkg::ACT_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
      repeat (10) queue_op(btb_pkg::ACT_UPDATE, 32'h0000_0100, 32'hFFFF_FFFF, 1'b1, 1'b0);
      queue_op(btb_pkg::ACT_PREDICT, 32'h0000_0100, 32'h0000_0000, 1'b0, 1'b0);
      repeat (4) queue_op(btb_pkg::ACT_UPDATE, 32'h0000_0100, 32'h8000_0000, 1'b0, 1'b0);
      queue_op(btb_pkg::ACT_PREDICT, 32'h0000_0100, 32'h0000_0000, 1'b0, 1'b0);
      queue_op(btb_pkg::ACT_UPDATE, 32'h0000_0180, 32'h1234_5678, 1'b1, 1'b1);
      queue_op(btb_pkg::ACT_PREDICT, 32'h0000_0100, 32'h0000_0000, 1'b0, 1'b0);
      queue_op(btb_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
      queue_op(btb_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
      queue_op(btb_pkg::ACT_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);

      run_phase(3'd0, 4'd1, 5'd0, 2'd0, 1'b0, 1'b0, btb_pkg::SHARE_NONE, 30, 147);
      run_phase(3'd7, 4'd15, 5'd31, 2'd3, 1'b0, 1'b0, 2'd3, 0, 147);
      run_phase(3'd3, 4'd0, 5'd2, 2'd2, 1'b0, 1'b0, btb_pkg::SHARE_LOW, 50, 147);
      run_phase(3'd6, 4'd4, 5'd12, 2'd1, 1'b0, 1'b0, btb_pkg::SHARE_HIGH, 20, 147);
      run_phase(3'd2, 4'd8, 5'd5, 2'd0, hist_first, ~hist_first, btb_pkg::SHARE_LOW, 80, 147);
      run_phase(3'd5, 4'd6, 5'd30, 2'd3, 1'b1, 1'b1, btb_pkg::SHARE_HIGH, 30, 147);
      run_phase(3'd1, 4'd3, 5'd1, 2'd2, 1'b1, 1'b1, btb_pkg::SHARE_NONE, 0, 147);
      run_phase(3'd4, 4'd8, 5'd20, 2'd1, 1'b1, 1'b1, 2'd3, 40, 147);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
